// File: rtl/core/sfd_pkg.sv
// Shared widths, constants, codes and the helper function of the stereo feedback delay.
package sfd_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int DELAY_W    = 16;
   localparam int FBGAIN_W   = 16;
   localparam int WETGAIN_W  = 17;
   localparam int RATE_W     = 18;
   localparam int SMOOTH_W   = 32;
   localparam int OFF_W      = 19;
   localparam int DLY_W      = 24;
   localparam int STEP_W     = 23;
   localparam int Z_W        = 30;
   localparam int Q_W        = 31;
   localparam int PROD_W     = 42;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam int ROUND_HALF = 32768;
   localparam int STEP_BIAS  = 999;
   localparam int RATE_MAX   = 192000;

   // floor(x/1000) = floor((x>>3) * ceil(2^37/125) >> 37) for x>>3 below 2^30
   localparam logic [31:0] STEP_RECIP = 32'd1099511628;
   localparam int          STEP_SHIFT = 37;
   // floor(p/65536000) = floor((p>>19) * ceil(2^38/125) >> 38) for p>>19 below 2^31
   localparam int          Q_SHIFT    = 19;
   localparam logic [31:0] DLY_RECIP  = 32'd2199023256;
   localparam int          DLY_SHIFT  = 38;

   localparam logic [DELAY_W-1:0]   DELAY_RST   = 16'd100;
   localparam logic [FBGAIN_W-1:0]  FBGAIN_RST  = 16'd45875;
   localparam logic [WETGAIN_W-1:0] WETGAIN_RST = 17'd32768;
   localparam logic [RATE_W-1:0]    RATE_RST    = 18'd48000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_MS    = 8'd0,
      CSR_FB_GAIN     = 8'd1,
      CSR_WET_GAIN    = 8'd2,
      CSR_SAMPLE_RATE = 8'd3
   } csr_idx_type;

   typedef struct packed {
      logic [DELAY_W-1:0]   delay_ms;
      logic [FBGAIN_W-1:0]  feedback_gain;
      logic [WETGAIN_W-1:0] wet_gain;
      logic [RATE_W-1:0]    sample_rate;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic smooth;
      logic step;
      logic update;
      logic mult;
      logic divide;
      logic taps;
      logic mod_q;
      logic mod_r;
      logic addr;
      logic sum;
      logic fb;
      logic write;
      logic load_out;
   } cmd_type;

   // Round half up on the Q16 fraction, then saturate to a 24-bit sample.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      r = (p + PROD_W'(ROUND_HALF)) >>> FRAC_W;
      if ((&r[PROD_W-1:SAMPLE_W-1]) || (~|r[PROD_W-1:SAMPLE_W-1])) begin
         return r[SAMPLE_W-1:0];
      end else if (r[PROD_W-1]) begin
         return {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

endpackage

// File: rtl/core/sfd_ifs.sv
// Channel interfaces of the stereo feedback delay: sample input, result output, register writes.
interface sfd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sfd_pkg::SAMPLE_W-1:0]  left_in;
   logic signed [sfd_pkg::SAMPLE_W-1:0]  right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sfd_pkg::SAMPLE_W-1:0]  dry_left;
   logic signed [sfd_pkg::SAMPLE_W-1:0]  wet_left;
   logic signed [sfd_pkg::SAMPLE_W-1:0]  wet_right;
   logic signed [sfd_pkg::SAMPLE_W-1:0]  dry_right;

   modport source (output valid, output dry_left, output wet_left, output wet_right,
                   output dry_right, input ready);
   modport sink   (input valid, input dry_left, input wet_left, input wet_right,
                   input dry_right, output ready);
endinterface

interface sfd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sfd_pkg::CSR_IDX_W-1:0]     index;
   logic [sfd_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/sfd_ctrl.sv
// Sequencer of the stereo feedback delay: steps one item through the datapath.
module sfd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sfd_pkg::cmd_type cmd
);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_SMOOTH = 14'b00000000000010,
      S_STEP   = 14'b00000000000100,
      S_UPDATE = 14'b00000000001000,
      S_MULT   = 14'b00000000010000,
      S_DIVIDE = 14'b00000000100000,
      S_TAPS   = 14'b00000001000000,
      S_MOD_Q  = 14'b00000010000000,
      S_MOD_R  = 14'b00000100000000,
      S_ADDR   = 14'b00001000000000,
      S_SUM    = 14'b00010000000000,
      S_FB     = 14'b00100000000000,
      S_WRITE  = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load_in  = (state_ff == S_IDLE) && req_valid;
      cmd.smooth   = (state_ff == S_SMOOTH);
      cmd.step     = (state_ff == S_STEP);
      cmd.update   = (state_ff == S_UPDATE);
      cmd.mult     = (state_ff == S_MULT);
      cmd.divide   = (state_ff == S_DIVIDE);
      cmd.taps     = (state_ff == S_TAPS);
      cmd.mod_q    = (state_ff == S_MOD_Q);
      cmd.mod_r    = (state_ff == S_MOD_R);
      cmd.addr     = (state_ff == S_ADDR);
      cmd.sum      = (state_ff == S_SUM);
      cmd.fb       = (state_ff == S_FB);
      cmd.write    = (state_ff == S_WRITE);
      cmd.load_out = (state_ff == S_OUT) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SMOOTH;
         S_SMOOTH: state_in = S_STEP;
         S_STEP:   state_in = S_UPDATE;
         S_UPDATE: state_in = S_MULT;
         S_MULT:   state_in = S_DIVIDE;
         S_DIVIDE: state_in = S_TAPS;
         S_TAPS:   state_in = S_MOD_Q;
         S_MOD_Q:  state_in = S_MOD_R;
         S_MOD_R:  state_in = S_ADDR;
         S_ADDR:   state_in = S_SUM;
         S_SUM:    state_in = S_FB;
         S_FB:     state_in = S_WRITE;
         S_WRITE:  state_in = S_OUT;
         // hold until the output register is free
         S_OUT:    if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> !req_ready)
      else $error("input taken while an item is in flight");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result load did not raise rsp valid");

endmodule

// File: rtl/core/sfd_chan.sv
// One audio channel: input line, feedback line, feedback and wet gain stages.
module sfd_chan #(
   parameter  int LINE_DEPTH = 524288,
   localparam int ADDR_W     = $clog2(LINE_DEPTH)
) (
   input  logic                                clock,
   input  sfd_pkg::cmd_type                    cmd,
   input  logic [ADDR_W-1:0]                   w,
   input  logic                                wrapped,
   input  logic [ADDR_W-1:0]                   in_idx,
   input  logic [ADDR_W-1:0]                   fb_idx,
   input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample,
   input  logic [sfd_pkg::FBGAIN_W-1:0]        fb_gain,
   input  logic [sfd_pkg::WETGAIN_W-1:0]       wet_gain,
   output logic signed [sfd_pkg::SAMPLE_W-1:0] wet
);

   localparam int SAMPLE_W = sfd_pkg::SAMPLE_W;
   localparam int PROD_W   = sfd_pkg::PROD_W;

   logic signed [SAMPLE_W-1:0] in_mem [LINE_DEPTH];
   logic signed [SAMPLE_W-1:0] fb_mem [LINE_DEPTH];

   logic signed [SAMPLE_W-1:0] in_rd_ff, fb_rd_ff;
   logic                       in_ok_ff, in_self_ff, fb_ok_ff;
   logic signed [SAMPLE_W-1:0] fb_ff;
   logic signed [PROD_W-1:0]   fb_prod_ff, fb_prod_in;
   logic signed [PROD_W-1:0]   wet_prod_ff, wet_prod_in;

   logic signed [SAMPLE_W-1:0] tap_in, tap_fb;
   logic signed [PROD_W-1:0]   sum_x, fbg_x, fb_x, wetg_x;

   // input line: write the current sample, read the input tap
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         in_mem[w] <= sample;
      end
      if (cmd.addr) begin
         in_rd_ff <= in_mem[in_idx];
      end
   end

   // feedback line: read the feedback tap, write the new feedback value
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         fb_mem[w] <= fb_ff;
      end
      if (cmd.addr) begin
         fb_rd_ff <= fb_mem[fb_idx];
      end
   end

   // Below w, or all once wrapped, hold written data; input tap at w gives sample; else zero.
   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         in_ok_ff   <= wrapped || (in_idx < w);
         in_self_ff <= (in_idx == w);
         fb_ok_ff   <= wrapped || (fb_idx < w);
      end
   end

   always_comb begin
      priority if (in_self_ff) begin
         tap_in = sample;
      end else if (in_ok_ff) begin
         tap_in = in_rd_ff;
      end else begin
         tap_in = '0;
      end
      tap_fb      = fb_ok_ff ? fb_rd_ff : '0;
      sum_x       = PROD_W'(tap_in) + PROD_W'(tap_fb);
      fbg_x       = PROD_W'({1'b0, fb_gain});
      fb_prod_in  = sum_x * fbg_x;
      fb_x        = PROD_W'(fb_ff);
      wetg_x      = PROD_W'({1'b0, wet_gain});
      wet_prod_in = fb_x * wetg_x;
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         fb_prod_ff <= fb_prod_in;
      end
      if (cmd.fb) begin
         fb_ff <= sfd_pkg::round_sat(fb_prod_ff);
      end
      if (cmd.write) begin
         wet_prod_ff <= wet_prod_in;
      end
   end

   assign wet = sfd_pkg::round_sat(wet_prod_ff);

endmodule

// File: rtl/core/sfd_dpath.sv
// Datapath: delay smoother, tap offsets, line addressing and the two channels.
module sfd_dpath #(
   parameter  int LINE_DEPTH = 524288,
   localparam int ADDR_W     = $clog2(LINE_DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sfd_pkg::cmd_type                    cmd,
   input  sfd_pkg::cfg_type                    cfg,
   input  logic signed [sfd_pkg::SAMPLE_W-1:0] left_in,
   input  logic signed [sfd_pkg::SAMPLE_W-1:0] right_in,
   output logic signed [sfd_pkg::SAMPLE_W-1:0] dry_left,
   output logic signed [sfd_pkg::SAMPLE_W-1:0] wet_left,
   output logic signed [sfd_pkg::SAMPLE_W-1:0] wet_right,
   output logic signed [sfd_pkg::SAMPLE_W-1:0] dry_right
);

   localparam int SAMPLE_W = sfd_pkg::SAMPLE_W;
   localparam int SMOOTH_W = sfd_pkg::SMOOTH_W;
   localparam int RATE_W   = sfd_pkg::RATE_W;
   localparam int OFF_W    = sfd_pkg::OFF_W;
   localparam int DLY_W    = sfd_pkg::DLY_W;
   localparam int STEP_W   = sfd_pkg::STEP_W;
   localparam int Z_W      = sfd_pkg::Z_W;
   localparam int Q_W      = sfd_pkg::Q_W;
   localparam int SPROD_W  = Z_W + 32;
   localparam int RPROD_W  = SMOOTH_W + RATE_W;
   localparam int DPROD_W  = Q_W + 32;

   localparam int NUM_TAPS = 3;
   localparam int TAP_A    = 0;
   localparam int TAP_B    = 1;
   localparam int TAP_C    = 2;

   // offset mod LINE_DEPTH by a rounded-up reciprocal, exact for OFF_W-bit offsets
   localparam int KREC = OFF_W + ADDR_W;
   localparam int MP_W = KREC + OFF_W;
   localparam logic [MP_W-1:0] MREC =
      MP_W'(((64'd1 << KREC) + 64'(LINE_DEPTH) - 64'd1) / 64'(LINE_DEPTH));
   localparam logic [OFF_W-1:0]  DEPTH_OFF = OFF_W'(LINE_DEPTH);
   localparam int                IDX_W     = ((ADDR_W > OFF_W) ? ADDR_W : OFF_W) + 1;
   localparam logic [IDX_W-1:0]  DEPTH_IDX = IDX_W'(LINE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_W    = ADDR_W'(LINE_DEPTH - 1);

   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic [SMOOTH_W-1:0]        s_ff, s_in;
   logic [Z_W-1:0]             z_ff, z_in;
   logic                       neg_ff, neg_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [Q_W-1:0]             q_ff, q_in;
   logic [DLY_W-1:0]           d_ff, d_in;
   logic [OFF_W-1:0]           off_ff  [NUM_TAPS];
   logic [OFF_W-1:0]           off_in  [NUM_TAPS];
   logic [OFF_W-1:0]           modq_ff [NUM_TAPS];
   logic [OFF_W-1:0]           modq_in [NUM_TAPS];
   logic [OFF_W-1:0]           rem_ff  [NUM_TAPS];
   logic [OFF_W-1:0]           rem_in  [NUM_TAPS];
   logic [ADDR_W-1:0]          idx     [NUM_TAPS];
   logic [ADDR_W-1:0]          w_ff, w_in;
   logic                       wrapped_ff, wrapped_in;
   logic signed [SAMPLE_W-1:0] dry_left_ff, wet_left_ff, wet_right_ff, dry_right_ff;
   logic signed [SAMPLE_W-1:0] wet_l, wet_r;

   logic [SMOOTH_W-1:0]        target;
   logic signed [SMOOTH_W:0]   diff;
   logic [SMOOTH_W:0]          mag;
   logic [SMOOTH_W:0]          biased;
   logic [SPROD_W-1:0]         sprod;
   logic [RPROD_W-1:0]         rprod;
   logic [DPROD_W-1:0]         dprod;
   logic [DLY_W:0]             d_x, d2_x, lim_x;
   logic [MP_W-1:0]            mprod [NUM_TAPS];
   logic [IDX_W-1:0]           w_x, r_x, back_x;

   // smoother: s moves toward delay_ms in Q16.16 by ceil(|T - s| / 1000)
   always_comb begin
      target = {cfg.delay_ms, 16'd0};
      diff   = $signed({1'b0, target}) - $signed({1'b0, s_ff});
      mag    = diff[SMOOTH_W] ? (SMOOTH_W+1)'(-diff) : (SMOOTH_W+1)'(diff);
      biased = mag + (SMOOTH_W+1)'(sfd_pkg::STEP_BIAS);
      z_in   = biased[3 +: Z_W];
      neg_in = diff[SMOOTH_W];
      sprod  = SPROD_W'(z_ff) * SPROD_W'(sfd_pkg::STEP_RECIP);
      step_in = sprod[sfd_pkg::STEP_SHIFT +: STEP_W];
      s_in   = neg_ff ? (s_ff - SMOOTH_W'(step_ff)) : (s_ff + SMOOTH_W'(step_ff));
   end

   // d = floor(s * rate / 65536000)
   always_comb begin
      rprod = RPROD_W'(s_ff) * RPROD_W'(cfg.sample_rate);
      q_in  = rprod[sfd_pkg::Q_SHIFT +: Q_W];
      dprod = DPROD_W'(q_ff) * DPROD_W'(sfd_pkg::DLY_RECIP);
      d_in  = dprod[sfd_pkg::DLY_SHIFT +: DLY_W];
   end

   // clamp taps to twice the rate; the feedback tap sits one past the right tap
   always_comb begin
      d_x    = (DLY_W+1)'(d_ff);
      d2_x   = {d_ff, 1'b0};
      lim_x  = (DLY_W+1)'({cfg.sample_rate, 1'b0});
      off_in[TAP_A] = (d_x < lim_x)  ? OFF_W'(d_x)  : OFF_W'(lim_x);
      off_in[TAP_B] = (d2_x < lim_x) ? OFF_W'(d2_x) : OFF_W'(lim_x);
      off_in[TAP_C] = off_in[TAP_B] + 1'b1;
   end

   always_comb begin
      w_x = IDX_W'(w_ff);
      for (int k = 0; k < NUM_TAPS; k++) begin
         mprod[k]   = MP_W'(off_ff[k]) * MREC;
         modq_in[k] = mprod[k][KREC +: OFF_W];
         rem_in[k]  = off_ff[k] - (modq_ff[k] * DEPTH_OFF);
      end
   end

   // line address: w - rem, wrapped into the line
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         r_x    = IDX_W'(rem_ff[k]);
         back_x = (w_x >= r_x) ? (w_x - r_x) : (w_x + DEPTH_IDX - r_x);
         idx[k] = back_x[ADDR_W-1:0];
      end
   end

   always_comb begin
      w_in       = (w_ff == LAST_W) ? '0 : w_ff + 1'b1;
      wrapped_in = wrapped_ff || (w_ff == LAST_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff       <= '0;
         w_ff       <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            s_ff <= s_in;
         end
         if (cmd.write) begin
            w_ff       <= w_in;
            wrapped_ff <= wrapped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
      if (cmd.smooth) begin
         z_ff   <= z_in;
         neg_ff <= neg_in;
      end
      if (cmd.step) begin
         step_ff <= step_in;
      end
      if (cmd.mult) begin
         q_ff <= q_in;
      end
      if (cmd.divide) begin
         d_ff <= d_in;
      end
      for (int k = 0; k < NUM_TAPS; k++) begin
         if (cmd.taps) begin
            off_ff[k] <= off_in[k];
         end
         if (cmd.mod_q) begin
            modq_ff[k] <= modq_in[k];
         end
         if (cmd.mod_r) begin
            rem_ff[k] <= rem_in[k];
         end
      end
      if (cmd.load_out) begin
         dry_left_ff  <= left_ff;
         wet_left_ff  <= wet_l;
         wet_right_ff <= wet_r;
         dry_right_ff <= right_ff;
      end
   end

   sfd_chan #(.LINE_DEPTH(LINE_DEPTH)) u_left (
      .clock    (clock),
      .cmd      (cmd),
      .w        (w_ff),
      .wrapped  (wrapped_ff),
      .in_idx   (idx[TAP_A]),
      .fb_idx   (idx[TAP_C]),
      .sample   (left_ff),
      .fb_gain  (cfg.feedback_gain),
      .wet_gain (cfg.wet_gain),
      .wet      (wet_l)
   );

   sfd_chan #(.LINE_DEPTH(LINE_DEPTH)) u_right (
      .clock    (clock),
      .cmd      (cmd),
      .w        (w_ff),
      .wrapped  (wrapped_ff),
      .in_idx   (idx[TAP_B]),
      .fb_idx   (idx[TAP_C]),
      .sample   (right_ff),
      .fb_gain  (cfg.feedback_gain),
      .wet_gain (cfg.wet_gain),
      .wet      (wet_r)
   );

   assign dry_left  = dry_left_ff;
   assign wet_left  = wet_left_ff;
   assign wet_right = wet_right_ff;
   assign dry_right = dry_right_ff;

   a_w_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> (w_ff == (($past(w_ff) == LAST_W) ? '0 : $past(w_ff) + 1'b1)))
      else $error("write index did not advance by one");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_r |=> (rem_ff[TAP_A] < DEPTH_IDX) && (rem_ff[TAP_B] < DEPTH_IDX)
                    && (rem_ff[TAP_C] < DEPTH_IDX))
      else $error("tap offset not reduced below line depth");

endmodule

// File: rtl/core/stereo_feedback_delay_top.sv
// Stereo feedback delay top level: register file, sequencer and datapath.
//
// One stereo pair enters per beat and yields one result beat with the dry pair and the
// two wet samples. Only one item is in flight: it passes every sequencer state from
// acceptance to its result in the output register, and the input accepts the next item
// the cycle after that result is loaded; a held output stalls only the last step. The
// pace is set by the chain of dependent steps per item: smoother update, rate scaling, tap
// wrap, one read per line, feedback multiplier, then line writes with the wet multiplier.
// The four lines start empty by tracking how far the write index has come since reset,
// so there is no clearing pass and the block takes items from the first cycle after reset.
module stereo_feedback_delay_top #(
   parameter int LINE_DEPTH = 524288
) (
   input logic        clock,
   input logic        reset,
   sfd_req_if.sink    req_port,
   sfd_rsp_if.source  rsp_port,
   sfd_csr_if.sink    csr_port
);

   logic [sfd_pkg::DELAY_W-1:0]   delay_ms_ff, delay_ms_in;
   logic [sfd_pkg::FBGAIN_W-1:0]  fb_gain_ff, fb_gain_in;
   logic [sfd_pkg::WETGAIN_W-1:0] wet_gain_ff, wet_gain_in;
   logic [sfd_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic [sfd_pkg::RATE_W-1:0]    rate_raw;
   sfd_pkg::cfg_type              cfg;
   sfd_pkg::cmd_type              cmd;

   assign csr_port.ready = 1'b1;

   // store the rate already clamped to 1..192000
   always_comb begin
      delay_ms_in = delay_ms_ff;
      fb_gain_in  = fb_gain_ff;
      wet_gain_in = wet_gain_ff;
      rate_in     = rate_ff;
      rate_raw    = csr_port.data[sfd_pkg::RATE_W-1:0];
      if (csr_port.valid) begin
         unique case (sfd_pkg::csr_idx_type'(csr_port.index))
            sfd_pkg::CSR_DELAY_MS:
               delay_ms_in = csr_port.data[sfd_pkg::DELAY_W-1:0];
            sfd_pkg::CSR_FB_GAIN:
               fb_gain_in = csr_port.data[sfd_pkg::FBGAIN_W-1:0];
            sfd_pkg::CSR_WET_GAIN:
               wet_gain_in = csr_port.data[sfd_pkg::WETGAIN_W-1:0];
            sfd_pkg::CSR_SAMPLE_RATE: begin
               priority if (rate_raw == '0) begin
                  rate_in = sfd_pkg::RATE_W'(1);
               end else if (rate_raw > sfd_pkg::RATE_W'(sfd_pkg::RATE_MAX)) begin
                  rate_in = sfd_pkg::RATE_W'(sfd_pkg::RATE_MAX);
               end else begin
                  rate_in = rate_raw;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ms_ff <= sfd_pkg::DELAY_RST;
         fb_gain_ff  <= sfd_pkg::FBGAIN_RST;
         wet_gain_ff <= sfd_pkg::WETGAIN_RST;
         rate_ff     <= sfd_pkg::RATE_RST;
      end else begin
         delay_ms_ff <= delay_ms_in;
         fb_gain_ff  <= fb_gain_in;
         wet_gain_ff <= wet_gain_in;
         rate_ff     <= rate_in;
      end
   end

   always_comb begin
      cfg.delay_ms      = delay_ms_ff;
      cfg.feedback_gain = fb_gain_ff;
      cfg.wet_gain      = wet_gain_ff;
      cfg.sample_rate   = rate_ff;
   end

   sfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd)
   );

   sfd_dpath #(.LINE_DEPTH(LINE_DEPTH)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg),
      .left_in   (req_port.left_in),
      .right_in  (req_port.right_in),
      .dry_left  (rsp_port.dry_left),
      .wet_left  (rsp_port.wet_left),
      .wet_right (rsp_port.wet_right),
      .dry_right (rsp_port.dry_right)
   );

endmodule

// File: tb/sfd_delay_checker.sv
// Checker for the stereo feedback delay: predicts every result beat and compares it.
`timescale 1ns / 1ps

module sfd_delay_checker #(
   parameter int LINE_DEPTH = 524288
) (
   input  logic  clock,
   input  logic  reset,
   sfd_req_if    req,
   sfd_rsp_if    rsp,
   sfd_csr_if    csr,
   output int    mismatch_count,
   output int    in_flight
);
   import sfd_pkg::*;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] dry_left;
      logic [SAMPLE_W-1:0] wet_left;
      logic [SAMPLE_W-1:0] wet_right;
      logic [SAMPLE_W-1:0] dry_right;
   } stereo_out_type;

   // Delay lines; 2-state, so they start cleared like the block after reset.
   int l_in_line [LINE_DEPTH];
   int l_fb_line [LINE_DEPTH];
   int r_in_line [LINE_DEPTH];
   int r_fb_line [LINE_DEPTH];

   logic [DELAY_W-1:0]   cfg_delay;
   logic [FBGAIN_W-1:0]  cfg_fbgain;
   logic [WETGAIN_W-1:0] cfg_wetgain;
   logic [RATE_W-1:0]    cfg_rate;
   logic [SMOOTH_W-1:0]  smooth_q16;
   int                   windex;

   stereo_out_type predicted_q[$];
   int             errs = 0;

   // Round half up on the Q16 fraction, then clamp to a 24-bit sample.
   function automatic int scale_q16(longint p);
      longint q;
      q = (p + 32768) >>> 16;
      if (q > 8388607) return 8388607;
      if (q < -8388608) return -8388608;
      return int'(q);
   endfunction

   function automatic int tap_back(int w, u64_type off);
      u64_type o;
      u64_type wu;
      o  = off % LINE_DEPTH;
      wu = w;
      return int'((wu + LINE_DEPTH - o) % LINE_DEPTH);
   endfunction

   function automatic stereo_out_type advance_delay(logic [SAMPLE_W-1:0] l,
                                                    logic [SAMPLE_W-1:0] r);
      u64_type        rate, lim, d, a, b, s64;
      longint         diff;
      int             w, fb;
      stereo_out_type o;
      rate = cfg_rate;
      if (rate < 1) rate = 1;
      if (rate > RATE_MAX) rate = RATE_MAX;
      w = windex;
      l_in_line[w] = $signed(l);

      // smoother step rounds away from zero so it lands on the target
      diff = longint'(cfg_delay) * 65536 - longint'(smooth_q16);
      if (diff > 0) smooth_q16 = smooth_q16 + 32'((diff + 999) / 1000);
      else if (diff < 0) smooth_q16 = smooth_q16 - 32'((-diff + 999) / 1000);

      s64 = smooth_q16;
      d   = (s64 * rate) / 64'd65536000;
      lim = 2 * rate;
      a   = (d < lim) ? d : lim;
      b   = (2 * d < lim) ? 2 * d : lim;

      fb = scale_q16((longint'(l_fb_line[tap_back(w, b + 1)])
                      + longint'(l_in_line[tap_back(w, a)])) * longint'(cfg_fbgain));
      l_fb_line[w] = fb;
      o.wet_left = SAMPLE_W'(scale_q16(longint'(fb) * longint'(cfg_wetgain)));

      r_in_line[w] = $signed(r);
      fb = scale_q16((longint'(r_fb_line[tap_back(w, b + 1)])
                      + longint'(r_in_line[tap_back(w, b)])) * longint'(cfg_fbgain));
      r_fb_line[w] = fb;
      o.wet_right = SAMPLE_W'(scale_q16(longint'(fb) * longint'(cfg_wetgain)));

      o.dry_left  = l;
      o.dry_right = r;
      windex = (w + 1) % LINE_DEPTH;
      return o;
   endfunction

   function automatic int check_field(string name, logic [SAMPLE_W-1:0] want,
                                      logic [SAMPLE_W-1:0] got);
      if (want === got) return 0;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name,
               $signed(want), $signed(got));
      return 1;
   endfunction

   always @(posedge clock) begin
      stereo_out_type want;
      stereo_out_type got;
      if (reset) begin
         cfg_delay   = DELAY_RST;
         cfg_fbgain  = FBGAIN_RST;
         cfg_wetgain = WETGAIN_RST;
         cfg_rate    = RATE_RST;
         smooth_q16  = '0;
         windex      = 0;
         predicted_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_DELAY_MS:    cfg_delay   = csr.data[DELAY_W-1:0];
               CSR_FB_GAIN:     cfg_fbgain  = csr.data[FBGAIN_W-1:0];
               CSR_WET_GAIN:    cfg_wetgain = csr.data[WETGAIN_W-1:0];
               CSR_SAMPLE_RATE: cfg_rate    = csr.data[RATE_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.dry_left, rsp.wet_left, rsp.wet_right, rsp.dry_right};
            if (predicted_q.size() == 0) begin
               $display("%0t result beat with no prediction waiting: expected none, actual %0h",
                        $time, got);
               errs++;
            end else begin
               want = predicted_q.pop_front();
               errs += check_field("dry_left", want.dry_left, got.dry_left);
               errs += check_field("wet_left", want.wet_left, got.wet_left);
               errs += check_field("wet_right", want.wet_right, got.wet_right);
               errs += check_field("dry_right", want.dry_right, got.dry_right);
            end
         end
         if (req.valid && req.ready) begin
            predicted_q.push_back(advance_delay(req.left_in, req.right_in));
         end
      end
      in_flight      <= predicted_q.size();
      mismatch_count <= errs;
   end

endmodule

// File: tb/testbench.sv
// Top of the stereo feedback delay testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import sfd_pkg::*;

   localparam int LINE_DEPTH     = 524288;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RX_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 30;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 110;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 8'd9;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

   localparam int unsigned DELAY_MASK = (1 << DELAY_W) - 1;
   localparam int unsigned FB_MASK    = (1 << FBGAIN_W) - 1;
   localparam int unsigned WET_MASK   = (1 << WETGAIN_W) - 1;
   localparam int unsigned RATE_MASK  = (1 << RATE_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit steady_tx = 1'b0;
   bit steady_rx = 1'b0;
   int hold_arm  = 0;

   int mismatch_count;
   int in_flight;

   sfd_req_if req_if ();
   sfd_rsp_if rsp_if ();
   sfd_csr_if csr_if ();

   stereo_feedback_delay_top #(.LINE_DEPTH(LINE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   sfd_delay_checker #(.LINE_DEPTH(LINE_DEPTH)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr            (csr_if),
      .mismatch_count (mismatch_count),
      .in_flight      (in_flight)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
      if (!steady_tx) begin
         while ($urandom_range(0, 99) < 35) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid    <= 1'b1;
      req_if.left_in  <= l;
      req_if.right_in <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stop offering and hold until every predicted beat is back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value,
                            input int unsigned mask, input bit spill);
      logic [CSR_DATA_W-1:0] junk;
      junk = spill ? ($urandom & ~mask) : '0;
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= (value & mask) | junk;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int unsigned delay_ms, input int unsigned fb_gain,
                             input int unsigned wet_gain, input int unsigned rate,
                             input bit spill);
      write_reg(CSR_DELAY_MS, delay_ms, DELAY_MASK, spill);
      write_reg(CSR_FB_GAIN, fb_gain, FB_MASK, spill);
      write_reg(CSR_WET_GAIN, wet_gain, WET_MASK, spill);
      write_reg(CSR_SAMPLE_RATE, rate, RATE_MASK, spill);
   endtask

   // Receiver: random stalls, steady stretches and one long hold-off on request.
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_arm != hold_seen) begin
            hold_seen = hold_arm;
            hold_left = RX_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (steady_rx) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 35);
         end
      end
   end

   // Watchdog: end the run when no channel moves a beat for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
             || (csr_if.valid && csr_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [SAMPLE_W-1:0] corner_vals [6];
      int unsigned rate;
      corner_vals[0] = SAMPLE_MAX;
      corner_vals[1] = SAMPLE_MIN;
      corner_vals[2] = '0;
      corner_vals[3] = 24'h000001;
      corner_vals[4] = 24'hFFFFFF;
      corner_vals[5] = 24'h555555;

      req_if.valid    <= 1'b0;
      req_if.left_in  <= '0;
      req_if.right_in <= '0;
      csr_if.valid    <= 1'b0;
      csr_if.index    <= '0;
      csr_if.data     <= '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings, corner samples, same and crossed pairs
      for (int i = 0; i < 6; i++) begin
         send_pair(corner_vals[i], corner_vals[i]);
         send_pair(corner_vals[i], corner_vals[(i + 3) % 6]);
      end

      // zero rate acts as one, wet gain beyond unity, maximum feedback gain
      drain_results();
      set_config(DELAY_MASK, FB_MASK, WET_MASK, 0, 1'b0);
      write_reg(CSR_NO_REG, $urandom, 32'hFFFFFFFF, 1'b0);
      for (int i = 0; i < 6; i++) send_pair(corner_vals[i], corner_vals[5 - i]);

      // rate above the top of range, gains at zero
      drain_results();
      set_config(DELAY_MASK, 0, 0, RATE_MASK, 1'b0);
      for (int i = 0; i < 4; i++) send_pair(corner_vals[i], corner_vals[i + 1]);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph)
            0: set_config(20, FB_MASK, 65536, 100, 1'b1);
            1: set_config(0, 0, 0, 1, 1'b0);
            2: set_config(DELAY_MASK, FB_MASK, WET_MASK, RATE_MASK, 1'b1);
            default: begin
               case ($urandom_range(0, 3))
                  0: rate = $urandom_range(1, RATE_MAX);
                  1: rate = $urandom_range(0, 4000);
                  2: rate = RATE_MAX;
                  default: rate = $urandom_range(RATE_MAX + 1, RATE_MASK);
               endcase
               set_config($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 131071), rate,
                          $urandom_range(0, 3) == 0);
            end
         endcase
         // one phase with no idling on either side, one where the receiver
         // holds off while the sender keeps offering
         steady_tx = (ph == 1) || (ph == 3);
         steady_rx = (ph == 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 3 && i == 20) hold_arm++;
            if (ph == 5 && i == 55) drain_results();
            send_pair(rand_sample(), rand_sample());
         end
      end

      drain_results();
      if (mismatch_count == 0 && in_flight == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: stereo_feedback_delay_top.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_ifs.sv
rtl/core/sfd_ctrl.sv
rtl/core/sfd_chan.sv
rtl/core/sfd_dpath.sv
rtl/core/stereo_feedback_delay_top.sv
tb/sfd_delay_checker.sv
tb/testbench.sv
